### rtl/sdc_pkg.sv
package sdc_pkg;

  localparam int CHIP_COUNT_DEF = 4;
  localparam int CH_PER_CHIP    = 8;
  localparam int CH_BITS        = 3;
  localparam int DATA_W         = 12;
  localparam int DATA_SHIFT     = 4;
  localparam int MAX_RESULTS    = 36;
  localparam int CNT_W          = $clog2(MAX_RESULTS + 1);
  localparam int PC_W           = 5;

  localparam logic [15:0] SETUP_WORD = 16'h9000;
  localparam logic [5:0]  ALL_CH     = 6'd32;

  localparam logic [1:0] OP_PON  = 2'd0;
  localparam logic [1:0] OP_POFF = 2'd1;
  localparam logic [1:0] OP_SET  = 2'd2;
  localparam logic [1:0] OP_LOWP = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BADCH = 2'd1;
  localparam logic [1:0] ST_UNPWR = 2'd2;
  localparam logic [1:0] ST_UNSUP = 2'd3;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  channel;
    logic [15:0] value;
  } in_t;

  typedef struct packed {
    logic        frame_valid;
    logic [15:0] frame_word;
    logic [1:0]  chip_index;
    logic [1:0]  status;
    logic        last;
  } out_t;

  // datapath action of one step
  typedef enum logic [3:0] {
    U_NOP,
    U_LOAD,
    U_CLR_IDX,
    U_EMIT_SETUP,
    U_EMIT_ZERO,
    U_EMIT_ONE,
    U_EMIT_ALL,
    U_SINGLE,
    U_POFF,
    U_PON_SET
  } uop_t;

  typedef enum logic [2:0] {
    BR_SEQ,
    BR_JMP,
    BR_COND,
    BR_LOOP,
    BR_OPC
  } br_t;

  typedef enum logic [2:0] {
    C_INFIRE,
    C_POWERED,
    C_CHEND,
    C_MORE,
    C_BAD,
    C_UNPWR,
    C_ALL,
    C_ALLEND
  } csel_t;

  typedef struct packed {
    uop_t       uop;
    br_t        br;
    csel_t      csel;
    logic [1:0] status;
    pc_t        target;
  } uword_t;

  typedef struct packed {
    logic       in_fire;
    logic [1:0] opcode;
    logic       powered;
    logic       chend;
    logic       more;
    logic       bad;
    logic       all;
    logic       allend;
    logic       slot_free;
  } cond_t;

  typedef struct packed {
    uop_t       uop;
    logic [1:0] status;
    logic       adv;
    logic       idle;
  } ctrl_t;

  localparam pc_t S_IDLE     = 5'd0;
  localparam pc_t S_DISPATCH = 5'd1;
  localparam pc_t S_PON_CHK  = 5'd2;
  localparam pc_t S_SETUP    = 5'd3;
  localparam pc_t S_ZERO     = 5'd4;
  localparam pc_t S_CHIP_NXT = 5'd5;
  localparam pc_t S_PON_SET  = 5'd6;
  localparam pc_t S_POFF     = 5'd7;
  localparam pc_t S_SET_BAD  = 5'd8;
  localparam pc_t S_SET_PWR  = 5'd9;
  localparam pc_t S_SET_ALL  = 5'd10;
  localparam pc_t S_SET_ONE  = 5'd11;
  localparam pc_t S_ALL      = 5'd12;
  localparam pc_t S_ALL_DONE = 5'd13;
  localparam pc_t S_LOWP     = 5'd14;
  localparam pc_t S_STAT0    = 5'd15;
  localparam pc_t S_STAT1    = 5'd16;
  localparam pc_t S_STAT2    = 5'd17;

  function automatic uword_t mk(uop_t u, br_t b, csel_t c, logic [1:0] st, pc_t t);
    uword_t w;
    w.uop    = u;
    w.br     = b;
    w.csel   = c;
    w.status = st;
    w.target = t;
    return w;
  endfunction

  function automatic uword_t rom(pc_t pc);
    uword_t w;
    case (pc)
      S_IDLE:     w = mk(U_LOAD,       BR_LOOP, C_INFIRE,  ST_OK,    S_IDLE);
      S_DISPATCH: w = mk(U_CLR_IDX,    BR_OPC,  C_INFIRE,  ST_OK,    S_IDLE);
      S_PON_CHK:  w = mk(U_NOP,        BR_COND, C_POWERED, ST_OK,    S_STAT0);
      S_SETUP:    w = mk(U_EMIT_SETUP, BR_SEQ,  C_INFIRE,  ST_OK,    S_IDLE);
      S_ZERO:     w = mk(U_EMIT_ZERO,  BR_LOOP, C_CHEND,   ST_OK,    S_IDLE);
      S_CHIP_NXT: w = mk(U_NOP,        BR_COND, C_MORE,    ST_OK,    S_SETUP);
      S_PON_SET:  w = mk(U_PON_SET,    BR_JMP,  C_INFIRE,  ST_OK,    S_IDLE);
      S_POFF:     w = mk(U_POFF,       BR_JMP,  C_INFIRE,  ST_OK,    S_STAT0);
      S_SET_BAD:  w = mk(U_NOP,        BR_COND, C_BAD,     ST_OK,    S_STAT1);
      S_SET_PWR:  w = mk(U_NOP,        BR_COND, C_UNPWR,   ST_OK,    S_STAT2);
      S_SET_ALL:  w = mk(U_NOP,        BR_COND, C_ALL,     ST_OK,    S_ALL);
      S_SET_ONE:  w = mk(U_EMIT_ONE,   BR_JMP,  C_INFIRE,  ST_OK,    S_IDLE);
      S_ALL:      w = mk(U_EMIT_ALL,   BR_LOOP, C_ALLEND,  ST_OK,    S_IDLE);
      S_ALL_DONE: w = mk(U_NOP,        BR_JMP,  C_INFIRE,  ST_OK,    S_IDLE);
      S_LOWP:     w = mk(U_SINGLE,     BR_JMP,  C_INFIRE,  ST_UNSUP, S_IDLE);
      S_STAT0:    w = mk(U_SINGLE,     BR_JMP,  C_INFIRE,  ST_OK,    S_IDLE);
      S_STAT1:    w = mk(U_SINGLE,     BR_JMP,  C_INFIRE,  ST_BADCH, S_IDLE);
      S_STAT2:    w = mk(U_SINGLE,     BR_JMP,  C_INFIRE,  ST_UNPWR, S_IDLE);
      default:    w = mk(U_NOP,        BR_JMP,  C_INFIRE,  ST_OK,    S_IDLE);
    endcase
    return w;
  endfunction

  function automatic pc_t opc_base(logic [1:0] opcode);
    pc_t p;
    case (opcode)
      OP_PON:  p = S_PON_CHK;
      OP_POFF: p = S_POFF;
      OP_SET:  p = S_SET_BAD;
      OP_LOWP: p = S_LOWP;
      default: p = S_IDLE;
    endcase
    return p;
  endfunction

  function automatic logic is_emit(uop_t u);
    return u inside {U_EMIT_SETUP, U_EMIT_ZERO, U_EMIT_ONE, U_EMIT_ALL, U_SINGLE};
  endfunction

endpackage

### rtl/sdc_useq.sv
module sdc_useq (
  input  logic          clk,
  input  logic          rst_n,
  input  sdc_pkg::cond_t cond,
  output sdc_pkg::ctrl_t ctrl
);

  sdc_pkg::pc_t    pc_r;
  sdc_pkg::pc_t    pc_nxt;
  sdc_pkg::uword_t uw;
  logic            c;
  logic            adv;

  assign uw  = sdc_pkg::rom(pc_r);
  // hold an emitting step until the output register can take its item
  assign adv = !sdc_pkg::is_emit(uw.uop) || cond.slot_free;

  always_comb begin
    case (uw.csel)
      sdc_pkg::C_INFIRE:  c = cond.in_fire;
      sdc_pkg::C_POWERED: c = cond.powered;
      sdc_pkg::C_CHEND:   c = cond.chend;
      sdc_pkg::C_MORE:    c = cond.more;
      sdc_pkg::C_BAD:     c = cond.bad;
      sdc_pkg::C_UNPWR:   c = !cond.powered;
      sdc_pkg::C_ALL:     c = cond.all;
      sdc_pkg::C_ALLEND:  c = cond.allend;
      default:            c = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt = pc_r;
    if (adv) begin
      case (uw.br)
        sdc_pkg::BR_SEQ:  pc_nxt = pc_r + 1'b1;
        sdc_pkg::BR_JMP:  pc_nxt = uw.target;
        sdc_pkg::BR_COND: pc_nxt = c ? uw.target : pc_r + 1'b1;
        sdc_pkg::BR_LOOP: pc_nxt = c ? pc_r + 1'b1 : pc_r;
        sdc_pkg::BR_OPC:  pc_nxt = sdc_pkg::opc_base(cond.opcode);
        default:          pc_nxt = sdc_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= sdc_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_comb begin
    ctrl.uop    = uw.uop;
    ctrl.status = uw.status;
    ctrl.adv    = adv;
    ctrl.idle   = (pc_r == sdc_pkg::S_IDLE);
  end

endmodule

### rtl/spi_dac_command_sequencer_top.sv
// Command sequencer for a bank of CHIP_COUNT octal 12-bit SPI DACs. Each command item
// turns into one or more result items: SPI frames (16-bit word plus the chip whose sync
// line is asserted) or a single status item, with last set on the final one. A
// microcoded step counter runs one step per cycle while no emitting step waits on the
// output, and each frame takes one step through a single output register. One command
// at a time: a command is taken only when the sequencer is back at its idle step.
// Power-on from unpowered gives a setup frame and zero frames for every chip (frames
// capped at 36). A stalled output holds the sequencer on the waiting frame.
module spi_dac_command_sequencer_top #(
  parameter int CHIP_COUNT = sdc_pkg::CHIP_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sdc_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output sdc_pkg::out_t out_item
);

  localparam int TOTAL = CHIP_COUNT * sdc_pkg::CH_PER_CHIP;
  localparam int IDX_W = $clog2(TOTAL + 1);

  sdc_pkg::cond_t cond;
  sdc_pkg::ctrl_t ctrl;

  logic                           powered_r, powered_nxt;
  logic [5:0]                     chan_r;
  logic [1:0]                     op_r;
  logic [sdc_pkg::DATA_W-1:0]     data_r;
  logic [IDX_W-1:0]               idx_r, idx_nxt;
  logic [sdc_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  sdc_pkg::out_t                  out_r, out_nxt;
  logic                           in_fire;
  logic                           slot_free;
  logic                           capped;
  logic                           cap_last;
  logic                           load;

  sdc_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ctrl  (ctrl)
  );

  assign in_ready  = ctrl.idle;
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign capped    = (cnt_r >= sdc_pkg::CNT_W'(sdc_pkg::MAX_RESULTS));
  assign cap_last  = (cnt_r == sdc_pkg::CNT_W'(sdc_pkg::MAX_RESULTS - 1));

  always_comb begin
    cond.in_fire   = in_fire;
    cond.opcode    = op_r;
    cond.powered   = powered_r;
    cond.chend     = &idx_r[sdc_pkg::CH_BITS-1:0];
    cond.more      = (idx_r != IDX_W'(TOTAL));
    cond.bad       = (chan_r != sdc_pkg::ALL_CH) && (int'(chan_r) >= TOTAL);
    cond.all       = (chan_r == sdc_pkg::ALL_CH);
    cond.allend    = (idx_r == IDX_W'(TOTAL - 1));
    cond.slot_free = slot_free;
  end

  always_comb begin
    powered_nxt = powered_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    out_nxt     = out_r;
    load        = 1'b0;
    if (ctrl.adv) begin
      case (ctrl.uop)
        sdc_pkg::U_CLR_IDX: begin
          idx_nxt = '0;
          cnt_nxt = '0;
        end
        sdc_pkg::U_EMIT_SETUP: begin
          out_nxt.frame_valid = 1'b1;
          out_nxt.frame_word  = sdc_pkg::SETUP_WORD;
          out_nxt.chip_index  = 2'(idx_r >> sdc_pkg::CH_BITS);
          out_nxt.status      = sdc_pkg::ST_OK;
          out_nxt.last        = cap_last;
          load                = !capped;
        end
        sdc_pkg::U_EMIT_ZERO, sdc_pkg::U_EMIT_ALL: begin
          out_nxt.frame_valid = 1'b1;
          out_nxt.frame_word  = {1'b0, idx_r[sdc_pkg::CH_BITS-1:0],
                                 (ctrl.uop == sdc_pkg::U_EMIT_ALL) ? data_r
                                                                   : sdc_pkg::DATA_W'(0)};
          out_nxt.chip_index  = 2'(idx_r >> sdc_pkg::CH_BITS);
          out_nxt.status      = sdc_pkg::ST_OK;
          out_nxt.last        = cap_last || cond.allend;
          load                = !capped;
          idx_nxt             = idx_r + 1'b1;
        end
        sdc_pkg::U_EMIT_ONE: begin
          out_nxt.frame_valid = 1'b1;
          out_nxt.frame_word  = {1'b0, chan_r[sdc_pkg::CH_BITS-1:0], data_r};
          out_nxt.chip_index  = 2'(chan_r >> sdc_pkg::CH_BITS);
          out_nxt.status      = sdc_pkg::ST_OK;
          out_nxt.last        = 1'b1;
          load                = 1'b1;
        end
        sdc_pkg::U_SINGLE: begin
          out_nxt.frame_valid = 1'b0;
          out_nxt.frame_word  = '0;
          out_nxt.chip_index  = '0;
          out_nxt.status      = ctrl.status;
          out_nxt.last        = 1'b1;
          load                = 1'b1;
        end
        sdc_pkg::U_POFF:    powered_nxt = 1'b0;
        sdc_pkg::U_PON_SET: powered_nxt = 1'b1;
        default: ;
      endcase
    end
    if (load && out_nxt.frame_valid) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      powered_r   <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      powered_r   <= powered_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
    if (in_fire) begin
      op_r   <= in_item.opcode;
      chan_r <= in_item.channel;
      data_r <= sdc_pkg::DATA_W'(in_item.value >> sdc_pkg::DATA_SHIFT);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_frame_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.frame_valid |-> out_item.status == sdc_pkg::ST_OK)
    else $error("frame item with nonzero status");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.frame_valid |-> out_item.last)
    else $error("status item without last");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= sdc_pkg::CNT_W'(sdc_pkg::MAX_RESULTS))
    else $error("frame count beyond cap");

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sequencer stayed idle after taking a command");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !load)
    else $error("output item overwritten while stalled");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int CHIPS    = sdc_pkg::CHIP_COUNT_DEF;
  localparam int CHANNELS = CHIPS * sdc_pkg::CH_PER_CHIP;

  logic          clk;
  logic          rst_n;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  sdc_pkg::in_t  in_item   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  sdc_pkg::out_t out_item;

  spi_dac_command_sequencer_top #(.CHIP_COUNT(CHIPS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  sdc_pkg::in_t  cmd_backlog[$];
  sdc_pkg::out_t frames_due[$];
  sdc_pkg::out_t burst[$];
  logic          bank_powered = 1'b0;

  int   send_idle_pct;
  int   recv_idle_pct;
  bit   recv_hold;
  bit   in_took;
  int   phase;
  int   hold_mark;
  int   cmds_taken   = 0;
  int   results_seen = 0;
  int   frames_seen  = 0;
  int   bcast_cmds   = 0;
  int   errors       = 0;
  int   status_seen[4] = '{default: 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // append one SPI frame, dropping anything past the per-command cap
  function automatic void add_frame(logic [15:0] word, int chip);
    sdc_pkg::out_t r;
    r.frame_valid = 1'b1;
    r.frame_word  = word;
    r.chip_index  = 2'(chip);
    r.status      = sdc_pkg::ST_OK;
    r.last        = 1'b0;
    if (burst.size() < sdc_pkg::MAX_RESULTS) burst.push_back(r);
  endfunction

  function automatic void add_status(logic [1:0] st);
    sdc_pkg::out_t r;
    r = '0;
    r.status = st;
    r.last   = 1'b1;
    burst.push_back(r);
  endfunction

  // work out the result items of one command and queue them
  function automatic void expand_command(sdc_pkg::in_t c);
    logic [11:0]   data;
    sdc_pkg::out_t r;
    data = c.value[15:sdc_pkg::DATA_SHIFT];
    burst.delete();
    case (c.opcode)
      sdc_pkg::OP_PON: begin
        if (bank_powered) begin
          add_status(sdc_pkg::ST_OK);
        end else begin
          for (int chip = 0; chip < CHIPS; chip++) begin
            add_frame(sdc_pkg::SETUP_WORD, chip);
            for (int ch = 0; ch < sdc_pkg::CH_PER_CHIP; ch++)
              add_frame({1'b0, 3'(ch), 12'h000}, chip);
          end
          bank_powered = 1'b1;
        end
      end
      sdc_pkg::OP_POFF: begin
        bank_powered = 1'b0;
        add_status(sdc_pkg::ST_OK);
      end
      sdc_pkg::OP_SET: begin
        if (c.channel != sdc_pkg::ALL_CH && c.channel >= CHANNELS) begin
          add_status(sdc_pkg::ST_BADCH);
        end else if (!bank_powered) begin
          add_status(sdc_pkg::ST_UNPWR);
        end else if (c.channel != sdc_pkg::ALL_CH) begin
          add_frame({1'b0, c.channel[2:0], data},
                    int'(c.channel) / sdc_pkg::CH_PER_CHIP);
        end else begin
          bcast_cmds++;
          for (int g = 0; g < CHANNELS; g++)
            add_frame({1'b0, 3'(g % sdc_pkg::CH_PER_CHIP), data},
                      g / sdc_pkg::CH_PER_CHIP);
        end
      end
      default: add_status(sdc_pkg::ST_UNSUP);
    endcase
    r = burst.pop_back();
    r.last = 1'b1;
    burst.push_back(r);
    foreach (burst[i]) frames_due.push_back(burst[i]);
  endfunction

  task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH at result %0d: %s got 0x%0h expected 0x%0h",
             results_seen, what, got, want);
    errors++;
  endtask

  // hold valid and payload until the item is taken
  always @(negedge clk) begin : drive_cmd
    logic         nv;
    sdc_pkg::in_t ni;
    nv = in_valid;
    ni = in_item;
    if (rst_n && (!in_valid || in_took)) begin
      nv = 1'b0;
      if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nv = 1'b1;
        ni = cmd_backlog.pop_front();
      end
    end
    in_valid  <= nv;
    in_item   <= ni;
    out_ready <= rst_n && !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : watch
    sdc_pkg::out_t want;
    in_took = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (frames_due.size() == 0) begin
          flag_mismatch("unexpected result, word", out_item.frame_word, 16'h0);
        end else begin
          want = frames_due.pop_front();
          if (out_item.frame_valid !== want.frame_valid)
            flag_mismatch("frame_valid", 16'(out_item.frame_valid),
                          16'(want.frame_valid));
          if (out_item.frame_word !== want.frame_word)
            flag_mismatch("frame_word", out_item.frame_word, want.frame_word);
          if (out_item.chip_index !== want.chip_index)
            flag_mismatch("chip_index", 16'(out_item.chip_index),
                          16'(want.chip_index));
          if (out_item.status !== want.status)
            flag_mismatch("status", 16'(out_item.status), 16'(want.status));
          if (out_item.last !== want.last)
            flag_mismatch("last", 16'(out_item.last), 16'(want.last));
          if (want.frame_valid) frames_seen++;
          status_seen[want.status]++;
        end
      end
      if (in_valid && in_ready) begin
        in_took = 1'b1;
        cmds_taken++;
        expand_command(in_item);
      end
    end
  end

  task automatic queue_cmd(logic [1:0] op, logic [5:0] ch, logic [15:0] v);
    sdc_pkg::in_t c;
    c.opcode  = op;
    c.channel = ch;
    c.value   = v;
    cmd_backlog.push_back(c);
  endtask

  // mostly set-value traffic with the bank powered; some rejects and power cycling
  task automatic queue_random(int n);
    int          pick;
    int          r;
    logic [5:0]  ch;
    logic [1:0]  op;
    repeat (n) begin
      pick = $urandom_range(99);
      ch   = 6'($urandom_range(63));
      if (pick < 8) begin
        op = sdc_pkg::OP_PON;
      end else if (pick < 14) begin
        op = sdc_pkg::OP_POFF;
      end else if (pick < 20) begin
        op = sdc_pkg::OP_LOWP;
      end else begin
        op = sdc_pkg::OP_SET;
        r  = $urandom_range(99);
        if (r < 12) ch = sdc_pkg::ALL_CH;
        else if (r < 24) ch = 6'($urandom_range(63, 33));
        else ch = 6'($urandom_range(CHANNELS - 1));
      end
      queue_cmd(op, ch, 16'($urandom));
    end
  endtask

  // sender pause: nothing new until every result is back
  task automatic drain;
    while (cmd_backlog.size() > 0 || in_valid || frames_due.size() > 0)
      @(posedge clk);
  endtask

  // long receiver stall while commands keep coming, so the input backs up
  initial begin
    recv_hold = 1'b0;
    wait (phase == 3 && cmds_taken >= hold_mark);
    recv_hold = 1'b1;
    repeat (400) @(posedge clk);
    recv_hold = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d commands taken, %0d results pending",
             cmds_taken, frames_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 86;
    phase         = 1;
    hold_mark     = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // unpowered rejects, bad channel checked before power
    queue_cmd(sdc_pkg::OP_SET,  6'd0,  16'h1234);
    queue_cmd(sdc_pkg::OP_SET,  6'd33, 16'hFFFF);
    queue_cmd(sdc_pkg::OP_SET,  6'd63, 16'h0000);
    queue_cmd(sdc_pkg::OP_SET,  sdc_pkg::ALL_CH, 16'h5A5A);
    queue_cmd(sdc_pkg::OP_LOWP, 6'd17, 16'hA5A5);
    queue_cmd(sdc_pkg::OP_POFF, 6'd5,  16'h0F0F);
    queue_cmd(sdc_pkg::OP_PON,  6'd0,  16'hF0F0);
    queue_cmd(sdc_pkg::OP_PON,  6'd63, 16'hFFFF);
    queue_cmd(sdc_pkg::OP_SET,  6'd0,  16'h0000);
    queue_cmd(sdc_pkg::OP_SET,  6'd31, 16'hFFFF);
    queue_cmd(sdc_pkg::OP_SET,  6'd7,  16'h000F);
    queue_cmd(sdc_pkg::OP_SET,  6'd8,  16'h8000);
    queue_cmd(sdc_pkg::OP_SET,  sdc_pkg::ALL_CH, 16'hABCD);
    queue_cmd(sdc_pkg::OP_SET,  sdc_pkg::ALL_CH, 16'hFFFF);
    queue_cmd(sdc_pkg::OP_LOWP, 6'd0,  16'h0000);
    queue_cmd(sdc_pkg::OP_SET,  6'd40, 16'h7FF0);
    queue_cmd(sdc_pkg::OP_POFF, 6'd63, 16'hFFFF);
    queue_cmd(sdc_pkg::OP_SET,  6'd5,  16'h4321);
    queue_cmd(sdc_pkg::OP_PON,  6'd32, 16'h0001);
    queue_random(40);
    drain();

    send_idle_pct = 86;
    recv_idle_pct = 19;
    phase         = 2;
    queue_random(52);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_mark     = cmds_taken + 5;
    phase         = 3;
    queue_random(50);
    drain();

    repeat (60) @(posedge clk);
    $display("Covered %0d commands (%0d all-channel writes) giving %0d results, %0d frames",
             cmds_taken, bcast_cmds, results_seen, frames_seen);
    $display("Statuses: ok %0d, bad channel %0d, not powered %0d, unsupported %0d",
             status_seen[sdc_pkg::ST_OK], status_seen[sdc_pkg::ST_BADCH],
             status_seen[sdc_pkg::ST_UNPWR], status_seen[sdc_pkg::ST_UNSUP]);
    if (errors == 0 && frames_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, frames_due.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/sdc_pkg.sv
rtl/sdc_useq.sv
rtl/spi_dac_command_sequencer_top.sv
tb/sv/tb_top.sv
